// ----- src/ffpa_pkg.sv -----
// Shared types and constants for the first-fit pool allocator.
`default_nettype none

package ffpa_pkg;

    localparam int POOL_WORDS = 16384;
    localparam int IDX_W      = (POOL_WORDS > 1) ? $clog2(POOL_WORDS) : 1;
    localparam longint CAP_RAW = 4 * longint'(POOL_WORDS);
    localparam logic [16:0] POOL_CAP = 17'((CAP_RAW > 65536) ? 65536 : CAP_RAW);
    localparam logic [16:0] MIN_POOL = 17'd8;
    localparam logic [1:0]  ALIGN_MASK = 2'h3;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef struct packed {
        logic        used;
        logic [16:0] size;
    } t_hdr;

    typedef struct packed {
        logic             we;
        logic             re;
        logic [IDX_W-1:0] addr;
        t_hdr             wdata;
    } t_mem_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CHK,
        S_DEC,
        S_WR_SPLIT,
        S_WR_HDR,
        S_FR_WR,
        S_DONE
    } t_state;

    function automatic logic [IDX_W-1:0] off2idx(input logic [16:0] off);
        return IDX_W'(off >> 2);
    endfunction

endpackage

`default_nettype wire

// ----- src/first_fit_pool_allocator_unit.sv -----
// Top level of the first-fit pool allocator: pool size register, RAM, walker.
//
//   channel | direction | handshake                 | beat payload
//   --------+-----------+---------------------------+-----------------------------------
//   in      | input     | i_in_valid / o_in_ready   | mode, request_bytes, block_address
//   out     | output    | o_out_valid / i_out_ready | granted_address, success
//   cfg     | input     | i_cfg_wr_en               | pool_size (no wait, no read-back)
//
// One operation at a time, from the accepting edge to the result beat.
// Allocate: one header read per header visited, plus 1 or 2 header writes on a grant.
// Free: reads the freed header and each following header, the used one ending a merge
// included, then one header write. All share the single header RAM port (one read or write a cycle, registered read).
// Rejected requests skip the header walk. Reset is synchronous; the pool reads
// as uninitialized until pool_size is written. A stalled output holds the walker
// in its last state; the next beat is taken once the result moves to the output.
`default_nettype none

module first_fit_pool_allocator_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [16:0] i_cfg_wr_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_mode,
    input  wire logic [16:0] i_request_bytes,
    input  wire logic [15:0] i_block_address,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [15:0]      o_granted_address,
    output logic             o_success
);
    import ffpa_pkg::*;

    logic [16:0] r_pool;
    logic [16:0] w_pool_al;
    logic [16:0] w_pool_cap;
    logic [16:0] w_pool_lim;
    t_mem_req    w_walk_req;
    t_mem_req    w_mem_req;
    t_hdr        w_rdata;

    assign w_pool_al  = {i_cfg_wr_data[16:2], 2'b00};
    assign w_pool_cap = (w_pool_al > POOL_CAP) ? POOL_CAP : w_pool_al;
    assign w_pool_lim = (w_pool_cap < MIN_POOL) ? 17'd0 : w_pool_cap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool <= 17'd0;
        end else if (i_cfg_wr_en) begin
            r_pool <= w_pool_lim;
        end
    end

    // a config write formats the pool as one free block
    always_comb begin
        w_mem_req = w_walk_req;
        if (i_cfg_wr_en) begin
            w_mem_req.we         = (w_pool_lim != 17'd0);
            w_mem_req.re         = 1'b0;
            w_mem_req.addr       = '0;
            w_mem_req.wdata.used = 1'b0;
            w_mem_req.wdata.size = w_pool_lim - 17'd4;
        end
    end

    ffpa_hdr_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (w_mem_req),
        .o_rdata (w_rdata)
    );

    ffpa_walker u_walker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_pool_size       (r_pool),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_mode            (i_mode),
        .i_request_bytes   (i_request_bytes),
        .i_block_address   (i_block_address),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_granted_address (o_granted_address),
        .o_success         (o_success),
        .o_mem             (w_walk_req),
        .i_rdata           (w_rdata)
    );

`ifndef NO_ASSERTIONS
    a_grant_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_granted_address != 16'd0)) |-> o_success)
        else $error("granted address without success");

    a_grant_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_granted_address[1:0] == 2'b00))
        else $error("granted address not word aligned");

    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while an operation is in flight");

    a_pool_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pool[1:0] == 2'b00) && ((r_pool == 17'd0) || (r_pool >= MIN_POOL)))
        else $error("pool size register out of range");
`endif

endmodule

`default_nettype wire

// ----- src/ffpa_hdr_ram.sv -----
// Header store: single-port synchronous RAM, registered read.
`default_nettype none

module ffpa_hdr_ram (
    input  wire logic            i_clk,
    input  wire ffpa_pkg::t_mem_req i_req,
    output ffpa_pkg::t_hdr       o_rdata
);
    import ffpa_pkg::*;

    t_hdr mem [POOL_WORDS];
    t_hdr r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- src/ffpa_walker.sv -----
// Header walk sequencer: allocate and free operations, result register.
`default_nettype none

module ffpa_walker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [16:0]        i_pool_size,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic               i_mode,
    input  wire logic [16:0]        i_request_bytes,
    input  wire logic [15:0]        i_block_address,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [15:0]             o_granted_address,
    output logic                    o_success,
    output ffpa_pkg::t_mem_req      o_mem,
    input  wire ffpa_pkg::t_hdr     i_rdata
);
    import ffpa_pkg::*;

    t_state r_state, n_state;
    logic        r_mode, n_mode;
    logic [17:0] r_req, n_req;
    logic [16:0] r_off, n_off;
    logic [16:0] r_base, n_base;
    logic [16:0] r_have, n_have;
    logic        r_used, n_used;
    logic [16:0] r_give, n_give;
    logic [16:0] r_size, n_size;
    logic        r_first, n_first;
    logic        r_ok, n_ok;
    logic [15:0] r_gaddr, n_gaddr;
    logic        r_ovalid, n_ovalid;
    logic [15:0] r_oaddr, n_oaddr;
    logic        r_osucc, n_osucc;

    logic        w_accept;
    logic [17:0] w_req_sum;
    logic [17:0] w_req_rnd;
    logic        w_alloc_bad;
    logic        w_free_bad;
    logic [16:0] w_room;
    logic [16:0] w_have;
    logic [17:0] w_next;
    logic        w_end;
    logic        w_fit;
    logic [16:0] w_give;
    logic        w_stop;
    logic        w_load;

    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign w_req_sum   = {1'b0, i_request_bytes} + 18'd3;
    assign w_req_rnd   = {w_req_sum[17:2], 2'b00};
    assign w_alloc_bad = (i_request_bytes == 17'd0) || (i_pool_size == 17'd0);
    assign w_free_bad  = (i_pool_size == 17'd0) || (i_block_address == 16'd0)
                      || ((i_block_address[1:0] & ALIGN_MASK) != 2'b00)
                      || ({1'b0, i_block_address} >= i_pool_size);

    // clip the header size to the pool end
    assign w_room  = i_pool_size - r_off - 17'd4;
    assign w_have  = (i_rdata.size > w_room) ? w_room : i_rdata.size;
    assign w_next  = {1'b0, r_off} + 18'd4 + {1'b0, r_have};
    assign w_end   = (w_next + 18'd4) >= {1'b0, i_pool_size};
    assign w_fit   = !r_used && ({1'b0, r_have} >= r_req);
    assign w_give  = ({1'b0, r_have} == r_req + 18'd8) ? r_have : r_req[16:0];
    assign w_stop  = !r_first && r_used;
    assign w_load  = (r_state == S_DONE) && (!r_ovalid || i_out_ready);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_mode == MODE_ALLOC) begin
                        n_state = w_alloc_bad ? S_DONE : S_RD;
                    end else begin
                        n_state = w_free_bad ? S_DONE : S_RD;
                    end
                end
            end
            S_RD:  n_state = S_CHK;
            S_CHK: n_state = S_DEC;
            S_DEC: begin
                if (r_mode == MODE_ALLOC) begin
                    if (w_fit) begin
                        n_state = (r_have != w_give) ? S_WR_SPLIT : S_WR_HDR;
                    end else begin
                        n_state = w_end ? S_DONE : S_CHK;
                    end
                end else begin
                    if (w_stop || w_end) begin
                        n_state = S_FR_WR;
                    end else begin
                        n_state = S_CHK;
                    end
                end
            end
            S_WR_SPLIT: n_state = S_WR_HDR;
            S_WR_HDR:   n_state = S_DONE;
            S_FR_WR:    n_state = S_DONE;
            S_DONE: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        n_mode   = r_mode;
        n_req    = r_req;
        n_off    = r_off;
        n_base   = r_base;
        n_have   = r_have;
        n_used   = r_used;
        n_give   = r_give;
        n_size   = r_size;
        n_first  = r_first;
        n_ok     = r_ok;
        n_gaddr  = r_gaddr;
        n_ovalid = r_ovalid;
        n_oaddr  = r_oaddr;
        n_osucc  = r_osucc;

        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_mode  = i_mode;
                    n_req   = w_req_rnd;
                    n_first = 1'b1;
                    n_ok    = 1'b0;
                    n_gaddr = 16'd0;
                    if (i_mode == MODE_ALLOC) begin
                        n_off  = 17'd0;
                        n_base = 17'd0;
                    end else begin
                        n_off  = {1'b0, i_block_address} - 17'd4;
                        n_base = {1'b0, i_block_address} - 17'd4;
                    end
                end
            end
            S_CHK: begin
                n_have = w_have;
                n_used = i_rdata.used;
            end
            S_DEC: begin
                if (r_mode == MODE_ALLOC) begin
                    if (w_fit) begin
                        n_give = w_give;
                    end else if (!w_end) begin
                        n_off = w_next[16:0];
                    end
                end else if (!w_stop) begin
                    n_first = 1'b0;
                    n_size  = r_first ? r_have : (r_size + r_have + 17'd4);
                    if (!w_end) begin
                        n_off = w_next[16:0];
                    end
                end
            end
            S_WR_HDR: begin
                n_ok    = 1'b1;
                n_gaddr = r_off[15:0] + 16'd4;
            end
            S_FR_WR: begin
                n_ok    = 1'b1;
                n_gaddr = 16'd0;
            end
            S_DONE: begin
                if (w_load) begin
                    n_ovalid = 1'b1;
                    n_oaddr  = r_gaddr;
                    n_osucc  = r_ok;
                end
            end
            default: ;
        endcase
    end

    // memory requests and handshake
    always_comb begin
        o_mem       = '0;
        o_in_ready  = 1'b0;
        unique case (r_state)
            S_IDLE: o_in_ready = 1'b1;
            S_RD: begin
                o_mem.re   = 1'b1;
                o_mem.addr = off2idx(r_off);
            end
            S_DEC: begin
                if (((r_mode == MODE_ALLOC) && !w_fit && !w_end)
                        || ((r_mode == MODE_FREE) && !w_stop && !w_end)) begin
                    o_mem.re   = 1'b1;
                    o_mem.addr = off2idx(w_next[16:0]);
                end
            end
            S_WR_SPLIT: begin
                o_mem.we         = 1'b1;
                o_mem.addr       = off2idx(r_off + 17'd4 + r_give);
                o_mem.wdata.used = 1'b0;
                o_mem.wdata.size = r_have - r_give - 17'd4;
            end
            S_WR_HDR: begin
                o_mem.we         = 1'b1;
                o_mem.addr       = off2idx(r_off);
                o_mem.wdata.used = 1'b1;
                o_mem.wdata.size = r_give;
            end
            S_FR_WR: begin
                o_mem.we         = 1'b1;
                o_mem.addr       = off2idx(r_base);
                o_mem.wdata.used = 1'b0;
                o_mem.wdata.size = r_size;
            end
            S_CHK, S_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode  <= n_mode;
        r_req   <= n_req;
        r_off   <= n_off;
        r_base  <= n_base;
        r_have  <= n_have;
        r_used  <= n_used;
        r_give  <= n_give;
        r_size  <= n_size;
        r_first <= n_first;
        r_ok    <= n_ok;
        r_gaddr <= n_gaddr;
        r_oaddr <= n_oaddr;
        r_osucc <= n_osucc;
    end

    assign o_out_valid       = r_ovalid;
    assign o_granted_address = r_oaddr;
    assign o_success         = r_osucc;

endmodule

`default_nettype wire

// ----- tb/tb_first_fit_pool_allocator_unit.sv -----
// Self-checking testbench for the first-fit pool allocator: directed cases, random traffic, stalls.
`timescale 1ns / 1ps

module tb_first_fit_pool_allocator_unit;
    import ffpa_pkg::*;

    typedef struct {
        logic [15:0] addr;
        logic        ok;
    } t_grant;

    typedef enum int {RX_ALWAYS, RX_HALF, RX_SPARSE, RX_PERIODIC} t_rx_style;

    localparam int MAX_SHOWN = 10;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [16:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        op_mode;
    logic [16:0] req_bytes;
    logic [15:0] blk_addr;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] grant_addr;
    logic        grant_ok;

    // predictor copy of the pool
    t_hdr        hdr_mem [POOL_WORDS];
    int unsigned pool_bytes;

    t_grant      grant_q [$];
    int unsigned used_starts [$];
    int unsigned free_starts [$];

    int err_count;
    int hold_cycles;
    int burst_left;
    int n_grants;
    int n_alloc_fail;
    int n_free_ok;
    int n_free_fail;
    int n_settings;

    first_fit_pool_allocator_unit DUT (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_wr_en       (cfg_we),
        .i_cfg_wr_data     (cfg_data),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_mode            (op_mode),
        .i_request_bytes   (req_bytes),
        .i_block_address   (blk_addr),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_granted_address (grant_addr),
        .o_success         (grant_ok)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [IDX_W-1:0] hidx(int unsigned off);
        return IDX_W'(off >> 2);
    endfunction

    function automatic int unsigned blk_len(int unsigned off);
        int unsigned s;
        int unsigned room;
        s = 32'(hdr_mem[hidx(off)].size);
        room = pool_bytes - off - 4;
        return (s > room) ? room : s;
    endfunction

    function automatic bit next_hdr(int unsigned off, output int unsigned nxt);
        nxt = off + 4 + blk_len(off);
        return (nxt + 4) < pool_bytes;
    endfunction

    function automatic void put_hdr(int unsigned off, logic used, int unsigned sz);
        hdr_mem[hidx(off)] = '{used: used, size: 17'(sz)};
    endfunction

    function automatic void apply_pool_size(int unsigned value);
        int unsigned p;
        p = value & 32'h1FFFC;
        if (p > POOL_CAP) p = 32'(POOL_CAP);
        if (p < MIN_POOL) p = 0;
        pool_bytes = p;
        if (p != 0) put_hdr(0, 1'b0, p - 4);
    endfunction

    function automatic bit predict_alloc(int unsigned req, output int unsigned addr);
        int unsigned off;
        int unsigned nxt;
        int unsigned have;
        int unsigned give;
        addr = 0;
        if (req == 0 || pool_bytes == 0) return 1'b0;
        if ((req & 3) != 0) req = (req & ~32'd3) + 4;
        off = 0;
        while (1) begin
            have = blk_len(off);
            if (!hdr_mem[hidx(off)].used && have >= req) begin
                // an 8-byte leftover is too small to keep, hand out the whole block
                give = (have == req + 8) ? have : req;
                if (have != give) put_hdr(off + 4 + give, 1'b0, have - give - 4);
                put_hdr(off, 1'b1, give);
                addr = off + 4;
                return 1'b1;
            end
            if (!next_hdr(off, nxt)) return 1'b0;
            off = nxt;
        end
    endfunction

    function automatic bit predict_free(int unsigned addr);
        int unsigned hdr;
        int unsigned size;
        int unsigned nxt;
        if (pool_bytes == 0 || addr == 0 || (addr & 3) != 0 || addr >= pool_bytes)
            return 1'b0;
        hdr = addr - 4;
        size = blk_len(hdr);
        put_hdr(hdr, 1'b0, size);
        while (next_hdr(hdr, nxt) && !hdr_mem[hidx(nxt)].used) begin
            size += blk_len(nxt) + 4;
            put_hdr(hdr, 1'b0, size);
        end
        return 1'b1;
    endfunction

    function automatic void scan_chain();
        int unsigned off;
        int unsigned nxt;
        used_starts.delete();
        free_starts.delete();
        if (pool_bytes == 0) return;
        off = 0;
        while (1) begin
            if (hdr_mem[hidx(off)].used) used_starts.push_back(off);
            else free_starts.push_back(off);
            if (!next_hdr(off, nxt)) break;
            off = nxt;
        end
    endfunction

    task automatic send_op(logic mode, int unsigned req, int unsigned addr);
        int gap;
        int unsigned ga;
        t_grant g;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid  <= 1'b1;
        op_mode   <= mode;
        req_bytes <= 17'(req);
        blk_addr  <= 16'(addr);
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        ga = 0;
        if (mode == MODE_ALLOC) begin
            g.ok = predict_alloc(req, ga);
            if (g.ok) n_grants++;
            else n_alloc_fail++;
        end else begin
            g.ok = predict_free(addr);
            if (g.ok) n_free_ok++;
            else n_free_fail++;
        end
        g.addr = 16'(ga);
        grant_q.push_back(g);
    endtask

    task automatic check_grant();
        t_grant g;
        if (grant_q.size() == 0) begin
            err_count++;
            if (err_count <= MAX_SHOWN)
                $display("%0t: unexpected result beat addr %0d ok %0b",
                         $time, grant_addr, grant_ok);
        end else begin
            g = grant_q.pop_front();
            if (grant_addr !== g.addr || grant_ok !== g.ok) begin
                err_count++;
                if (err_count <= MAX_SHOWN)
                    $display("%0t: mismatch: expected addr %0d ok %0b, got addr %0d ok %0b",
                             $time, g.addr, g.ok, grant_addr, grant_ok);
            end
        end
    endtask

    // only while idle: input low, all results back, walker settled
    task automatic set_pool(int unsigned value);
        in_valid <= 1'b0;
        while (grant_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= 17'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
        apply_pool_size(value & 32'h1FFFF);
        n_settings++;
    endtask

    task automatic random_op();
        int unsigned r;
        int unsigned req;
        int unsigned addr;
        int unsigned s;
        int unsigned k;
        scan_chain();
        r = $urandom_range(0, 99);
        req = $urandom_range(0, 65536);
        addr = $urandom_range(0, 65535);
        if (r < 45 || (r < 80 && used_starts.size() == 0)) begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
                req = $urandom_range(1, (pool_bytes > 24) ? pool_bytes / 6 : 4);
            end else if (r < 85 && free_starts.size() != 0) begin
                // exact fit, 4-byte and 8-byte leftovers
                s = blk_len(free_starts[$urandom_range(0, free_starts.size() - 1)]);
                k = 4 * $urandom_range(0, 2);
                req = (s > k) ? s - k - $urandom_range(0, 3) : 1;
            end else if (r < 93) begin
                req = $urandom_range(0, pool_bytes);
            end
            send_op(MODE_ALLOC, req, addr);
        end else if (r < 80) begin
            send_op(MODE_FREE, req, used_starts[$urandom_range(0, used_starts.size() - 1)] + 4);
        end else if (r < 90 && free_starts.size() != 0) begin
            send_op(MODE_FREE, req, free_starts[$urandom_range(0, free_starts.size() - 1)] + 4);
        end else begin
            case ($urandom_range(0, 2))
                0: addr = 0;
                1: addr = (addr & ~32'd3) | $urandom_range(1, 3);
                default: begin
                    if (pool_bytes <= 65535) addr = $urandom_range(pool_bytes, 65535);
                end
            endcase
            send_op(MODE_FREE, req, addr);
        end
    endtask

    task automatic test_uninitialized();
        send_op(MODE_ALLOC, 4, 0);
        send_op(MODE_FREE, 0, 4);
    endtask

    task automatic test_pool_rounding();
        set_pool(7);
        send_op(MODE_ALLOC, 4, 16'hFFFF);
        set_pool(17'h1FFFF);
        send_op(MODE_ALLOC, 65536, 0);
        send_op(MODE_ALLOC, 65535, 0);
        send_op(MODE_ALLOC, 65529, 0);
        send_op(MODE_FREE, 65536, 4);
        set_pool(8);
        send_op(MODE_ALLOC, 4, 0);
        send_op(MODE_ALLOC, 1, 0);
        send_op(MODE_FREE, 0, 4);
    endtask

    task automatic test_first_fit();
        set_pool(64);
        send_op(MODE_ALLOC, 0, 0);
        send_op(MODE_ALLOC, 1, 0);
        send_op(MODE_ALLOC, 44, 0);
        send_op(MODE_ALLOC, 4, 0);
        send_op(MODE_FREE, 0, 4);
        send_op(MODE_FREE, 0, 12);
        send_op(MODE_ALLOC, 56, 0);
        send_op(MODE_FREE, 0, 4);
        send_op(MODE_ALLOC, 56, 0);
        send_op(MODE_ALLOC, 1, 0);
        send_op(MODE_FREE, 0, 0);
        send_op(MODE_FREE, 0, 6);
        send_op(MODE_FREE, 0, 64);
        send_op(MODE_FREE, 0, 65532);
    endtask

    // stale header from a larger pool, size clipped at the new pool end
    task automatic test_trusted_free();
        set_pool(256);
        send_op(MODE_ALLOC, 16, 0);
        set_pool(64);
        send_op(MODE_FREE, 0, 24);
        send_op(MODE_ALLOC, 60, 0);
    endtask

    task automatic test_backpressure();
        int i;
        set_pool(256);
        hold_cycles = 400;
        for (i = 0; i < 40; i++) random_op();
    endtask

    task automatic test_random_traffic();
        int unsigned pools [11] = '{64, 100, 256, 8, 1022, 3, 65536, 17'h1FFFF, 512, 0, 128};
        int counts [11] = '{150, 150, 180, 60, 250, 15, 150, 100, 200, 10, 100};
        int p;
        int i;
        for (p = 0; p < 11; p++) begin
            set_pool(pools[p]);
            for (i = 0; i < counts[p]; i++) random_op();
        end
    endtask

    initial begin : rx_side
        t_rx_style style;
        int left;
        int phase;
        logic rdy;
        style = RX_ALWAYS;
        left = 100;
        phase = 0;
        out_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (out_valid && out_ready) check_grant();
            if (left == 0) begin
                style = t_rx_style'($urandom_range(0, 3));
                left = $urandom_range(20, 200);
            end
            left--;
            phase++;
            if (hold_cycles > 0) begin
                hold_cycles--;
                rdy = 1'b0;
            end else begin
                case (style)
                    RX_ALWAYS:   rdy = 1'b1;
                    RX_HALF:     rdy = ($urandom_range(0, 1) == 1);
                    RX_SPARSE:   rdy = ($urandom_range(0, 3) == 0);
                    default:     rdy = (phase % 3 != 0);
                endcase
            end
            out_ready <= rdy;
        end
    end

    initial begin
        #25_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        err_count = 0;
        hold_cycles = 0;
        burst_left = 0;
        n_grants = 0;
        n_alloc_fail = 0;
        n_free_ok = 0;
        n_free_fail = 0;
        n_settings = 0;
        pool_bytes = 0;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        op_mode   <= MODE_ALLOC;
        req_bytes <= '0;
        blk_addr  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_uninitialized();
        test_pool_rounding();
        test_first_fit();
        test_trusted_free();
        test_backpressure();
        test_random_traffic();

        in_valid <= 1'b0;
        while (grant_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        $display("Ran %0d pool settings: %0d grants, %0d refused allocates,",
                 n_settings, n_grants, n_alloc_fail);
        $display("%0d frees taken, %0d frees refused, %0d bad result beats.",
                 n_free_ok, n_free_fail, err_count);
        if (err_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
